// ===== rtl/core/fmsu_pkg.sv =====
`default_nettype none

package fmsu_pkg;

    localparam int FACTOR_COUNT_DEF = 16;

    localparam int VALUE_W   = 16;
    localparam int FIDX_W    = 6;
    localparam int ACC_W     = 27;
    localparam int SQ_W      = 45;
    localparam int VSQ_W     = 31;
    localparam int FPROD_W   = 54;
    localparam int SUM_W     = 60;
    localparam int DIFF_W    = SUM_W + 1;
    localparam int FULL_W    = DIFF_W + 1;
    localparam int SCORE_W   = 48;
    localparam int FRAC_SHIFT = 12;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [SQ_W-1:0] SQT_MAX = {1'b0, {(SQ_W-1){1'b1}}};

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_LINEAR,
        CLS_FACTOR
    } t_cls;

    typedef struct packed {
        t_cls                      cls;
        logic signed [VALUE_W-1:0] value;
        logic [FIDX_W-1:0]         fidx;
        logic                      last;
    } t_item;

    // Clamp a sum that has one guard bit back into the accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic [ACC_W:0] x);
        logic signed [ACC_W-1:0] res;
        if (x[ACC_W] != x[ACC_W-1]) begin
            res = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = x[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fmsu_ram.sv =====
`default_nettype none

module fmsu_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [W-1:0]       o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/fmsu_front.sv =====
`default_nettype none

module fmsu_front #(
    parameter int FACTOR_COUNT = fmsu_pkg::FACTOR_COUNT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_push,
    output logic                                      o_full,
    input  wire logic                                 i_kind,
    input  wire logic signed [fmsu_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [fmsu_pkg::FIDX_W-1:0]          i_factor_index,
    input  wire logic                                 i_last,
    output logic                                      o_q_valid,
    output fmsu_pkg::t_item                           o_q_item,
    input  wire logic                                 i_q_pop
);

    localparam int QD   = fmsu_pkg::QUEUE_DEPTH;
    localparam int QP_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    fmsu_pkg::t_item r_mem [QD];
    logic [QP_W-1:0] r_wptr;
    logic [QP_W-1:0] r_rptr;
    logic [QC_W-1:0] r_count;

    fmsu_pkg::t_item in_item;
    logic            push_ok;
    logic            pop_ok;

    always_comb begin
        in_item.value = i_value;
        in_item.fidx  = i_factor_index;
        in_item.last  = i_last;
        if (!i_kind) begin
            in_item.cls = fmsu_pkg::CLS_LINEAR;
        end else if ({1'b0, i_factor_index} < (fmsu_pkg::FIDX_W + 1)'(FACTOR_COUNT)) begin
            in_item.cls = fmsu_pkg::CLS_FACTOR;
        end else begin
            in_item.cls = fmsu_pkg::CLS_NONE;
        end
    end

    assign o_full    = (r_count == QC_W'(QD));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rptr];
    assign push_ok   = i_push && !o_full;
    assign pop_ok    = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= in_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == QP_W'(QD - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == QP_W'(QD - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(QD))
        else $error("front queue count beyond depth");
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("front queue count did not grow on a lone push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/fmsu_back.sv =====
`default_nettype none

module fmsu_back #(
    parameter int FACTOR_COUNT = fmsu_pkg::FACTOR_COUNT_DEF,
    localparam int FI_W = (FACTOR_COUNT > 1) ? $clog2(FACTOR_COUNT) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_q_valid,
    input  wire fmsu_pkg::t_item                     i_q_item,
    output logic                                     o_q_pop,
    output logic                                     o_empty,
    input  wire logic                                i_pop,
    output logic signed [fmsu_pkg::SCORE_W-1:0]      o_score,
    output logic                                     o_saturated
);

    localparam int ACC_W   = fmsu_pkg::ACC_W;
    localparam int SQ_W    = fmsu_pkg::SQ_W;
    localparam int VSQ_W   = fmsu_pkg::VSQ_W;
    localparam int FPROD_W = fmsu_pkg::FPROD_W;
    localparam int SUM_W   = fmsu_pkg::SUM_W;
    localparam int DIFF_W  = fmsu_pkg::DIFF_W;
    localparam int FULL_W  = fmsu_pkg::FULL_W;
    localparam int SCORE_W = fmsu_pkg::SCORE_W;
    localparam int VALUE_W = fmsu_pkg::VALUE_W;
    localparam int FRAC    = fmsu_pkg::FRAC_SHIFT;
    localparam logic [FI_W-1:0] LAST_IDX = FI_W'(FACTOR_COUNT - 1);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_REDUCE,
        ST_RWAIT,
        ST_DIFF,
        ST_EMIT
    } t_state;

    t_state r_state;

    // Accumulators.
    logic signed [ACC_W-1:0] r_lin;
    logic [SQ_W-1:0]         r_sqt;
    logic [FACTOR_COUNT-1:0] r_vbits;

    // Streaming pipeline: s1 updates the factor sum, s2 adds the square.
    logic                    r_s1_valid;
    logic [FI_W-1:0]         r_s1_idx;
    logic signed [VALUE_W-1:0] r_s1_val;
    logic                    r_wb_valid;
    logic [FI_W-1:0]         r_wb_idx;
    logic signed [ACC_W-1:0] r_wb_data;
    logic                    r_s2_valid;
    logic [VSQ_W-1:0]        r_s2_sq;

    // Reduction pipeline.
    logic [FI_W-1:0]         r_ridx;
    logic                    r_r1_valid;
    logic [FI_W-1:0]         r_r1_idx;
    logic                    r_r2_valid;
    logic [FPROD_W-1:0]      r_r2_prod;
    logic [SUM_W-1:0]        r_acc;
    logic signed [DIFF_W-1:0] r_diff;

    // Result slot.
    logic                    r_res_valid;
    logic signed [SCORE_W-1:0] r_res_score;
    logic                    r_res_sat;

    logic [FI_W-1:0]         ram_raddr;
    logic [ACC_W-1:0]        ram_rdata;
    logic                    pop_item;
    logic                    out_taken;
    logic                    slot_free;
    logic [ACC_W:0]          lin_raw;
    logic signed [ACC_W-1:0] s1_base;
    logic [ACC_W:0]          s1_raw;
    logic signed [ACC_W-1:0] s1_sum;
    logic signed [2*VALUE_W-1:0] s1_sq;
    logic [SQ_W:0]           sqt_raw;
    logic signed [ACC_W-1:0] r1_fs;
    logic signed [FPROD_W-1:0] r1_prod;
    logic [FULL_W-1:0]       score_full;
    logic                    score_ovf;
    logic signed [SCORE_W-1:0] score_sat;

    assign pop_item  = i_q_valid && (r_state == ST_RUN);
    assign o_q_pop   = pop_item;
    assign out_taken = i_pop && r_res_valid;
    assign slot_free = !r_res_valid || out_taken;
    assign o_empty     = !r_res_valid;
    assign o_score     = r_res_score;
    assign o_saturated = r_res_sat;

    assign ram_raddr = (r_state == ST_REDUCE) ? r_ridx : i_q_item.fidx[FI_W-1:0];

    fmsu_ram #(
        .W     (ACC_W),
        .DEPTH (FACTOR_COUNT)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (s1_sum),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        lin_raw = {r_lin[ACC_W-1], r_lin}
                + {{(ACC_W + 1 - VALUE_W){i_q_item.value[VALUE_W-1]}}, i_q_item.value};

        // The previous write lands on the same edge as this read, so it is forwarded.
        if (r_wb_valid && (r_wb_idx == r_s1_idx)) begin
            s1_base = r_wb_data;
        end else if (r_vbits[r_s1_idx]) begin
            s1_base = ram_rdata;
        end else begin
            s1_base = '0;
        end
        s1_raw = {s1_base[ACC_W-1], s1_base}
               + {{(ACC_W + 1 - VALUE_W){r_s1_val[VALUE_W-1]}}, r_s1_val};
        s1_sum = fmsu_pkg::sat_acc(s1_raw);
        s1_sq  = r_s1_val * r_s1_val;

        sqt_raw = {1'b0, r_sqt} + (SQ_W + 1)'(r_s2_sq);

        r1_fs   = r_vbits[r_r1_idx] ? ram_rdata : '0;
        r1_prod = r1_fs * r1_fs;

        score_full = {{(FULL_W - ACC_W - FRAC){r_lin[ACC_W-1]}}, r_lin, {FRAC{1'b0}}}
                   + {{2{r_diff[DIFF_W-1]}}, r_diff[DIFF_W-1:1]};
        score_ovf  = (score_full[FULL_W-1:SCORE_W-1] != {(FULL_W - SCORE_W + 1){1'b0}})
                  && (score_full[FULL_W-1:SCORE_W-1] != {(FULL_W - SCORE_W + 1){1'b1}});
        if (!score_ovf) begin
            score_sat = score_full[SCORE_W-1:0];
        end else if (score_full[FULL_W-1]) begin
            score_sat = {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            score_sat = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        // Payload registers.
        r_s1_idx  <= i_q_item.fidx[FI_W-1:0];
        r_s1_val  <= i_q_item.value;
        r_wb_idx  <= r_s1_idx;
        r_wb_data <= s1_sum;
        r_s2_sq   <= VSQ_W'(s1_sq);
        r_r1_idx  <= r_ridx;
        r_r2_prod <= FPROD_W'(r1_prod);

        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_lin       <= '0;
            r_sqt       <= '0;
            r_vbits     <= '0;
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_ridx      <= '0;
            r_r1_valid  <= 1'b0;
            r_r2_valid  <= 1'b0;
            r_acc       <= '0;
            r_diff      <= '0;
            r_res_valid <= 1'b0;
            r_res_score <= '0;
            r_res_sat   <= 1'b0;
        end else begin
            r_s1_valid <= pop_item && (i_q_item.cls == fmsu_pkg::CLS_FACTOR);
            r_wb_valid <= r_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_r1_valid <= (r_state == ST_REDUCE);
            r_r2_valid <= r_r1_valid;

            if (pop_item && (i_q_item.cls == fmsu_pkg::CLS_LINEAR)) begin
                r_lin <= fmsu_pkg::sat_acc(lin_raw);
            end
            if (r_s1_valid) begin
                r_vbits[r_s1_idx] <= 1'b1;
            end
            if (r_s2_valid) begin
                r_sqt <= (sqt_raw > {1'b0, fmsu_pkg::SQT_MAX}) ? fmsu_pkg::SQT_MAX
                                                               : sqt_raw[SQ_W-1:0];
            end
            if (r_r2_valid) begin
                r_acc <= r_acc + SUM_W'(r_r2_prod);
            end
            // In the emit state the slot is refilled below instead.
            if (out_taken && (r_state != ST_EMIT)) begin
                r_res_valid <= 1'b0;
            end

            unique case (r_state)
                ST_RUN: begin
                    if (pop_item && i_q_item.last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_valid && !r_s2_valid) begin
                        r_ridx  <= '0;
                        r_acc   <= '0;
                        r_state <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    r_ridx <= r_ridx + 1'b1;
                    if (r_ridx == LAST_IDX) begin
                        r_state <= ST_RWAIT;
                    end
                end
                ST_RWAIT: begin
                    if (!r_r1_valid && !r_r2_valid) begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_diff  <= {1'b0, r_acc} - DIFF_W'(r_sqt);
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_res_valid <= 1'b1;
                        r_res_score <= score_sat;
                        r_res_sat   <= score_ovf;
                        r_lin       <= '0;
                        r_sqt       <= '0;
                        r_vbits     <= '0;
                        r_state     <= ST_RUN;
                    end else if (out_taken) begin
                        r_res_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_reduce_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REDUCE) |-> (!r_s1_valid && !r_s2_valid))
        else $error("factor sums read for reduction while an update is in flight");
    a_sqt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sqt <= fmsu_pkg::SQT_MAX)
        else $error("square total above its saturation limit");
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && slot_free)
        |=> (r_lin == '0 && r_sqt == '0 && r_vbits == '0 && r_res_valid))
        else $error("accumulators not cleared when a score was issued");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/factorization_machine_score_unit.sv =====
`default_nettype none

// Second-order factorization machine scorer. Each sample streams in as items that are
// either a linear weight or one latent factor value with its factor index, all Q3.12;
// the item flagged last closes the sample and yields one Q23.24 score saturated to
// 48 bits, with a flag when clipping happened. Items are taken one per cycle while not
// full into a four-entry queue, and the accumulator side drains that queue at one item
// per cycle while it accumulates a sample, with the factor sums in a small RAM of
// FACTOR_COUNT entries. Closing a sample waits for factor updates still in flight, then
// runs the reduction that reads each factor sum once through the RAM's single read port
// and squares it; the queue keeps accepting during that time until it fills. A finished
// score waits in an output register until popped.
module factorization_machine_score_unit #(
    parameter int FACTOR_COUNT = fmsu_pkg::FACTOR_COUNT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_kind,
    input  wire logic signed [fmsu_pkg::VALUE_W-1:0] i_value,
    input  wire logic [fmsu_pkg::FIDX_W-1:0]         i_factor_index,
    input  wire logic                                i_last,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [fmsu_pkg::SCORE_W-1:0]      o_score,
    output logic                                     o_saturated
);

    logic            q_valid;
    logic            q_pop;
    fmsu_pkg::t_item q_item;

    fmsu_front #(
        .FACTOR_COUNT (FACTOR_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_factor_index (i_factor_index),
        .i_last         (i_last),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    fmsu_back #(
        .FACTOR_COUNT (FACTOR_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_score     (o_score),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire
